// File: src/sorted_timer_queue_assert.svh
// Assertion macros used by the sorted timer queue checker.
`ifndef SORTED_TIMER_QUEUE_ASSERT_SVH
`define SORTED_TIMER_QUEUE_ASSERT_SVH

// Clocked assertion that is switched off while reset is held.
`define STQ_ASSERT(name, prop, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Clocked assertion that also holds while reset is held.
`define STQ_ASSERT_RST(name, prop, msg) \
    name: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// File: src/stq_pkg.sv
// Shared sizes, codes and types of the sorted timer queue.
package stq_pkg;

    localparam int CAPACITY    = 64;
    localparam int TIME_BITS   = 48;
    localparam int ID_BITS     = 32;
    localparam int DELAY_BITS  = 32;
    localparam int SLEEP_BITS  = 33;
    localparam int KIND_BITS   = 2;
    localparam int STATUS_BITS = 2;
    localparam int ADDR_BITS   = $clog2(CAPACITY);
    localparam int KEY_BITS    = TIME_BITS + ID_BITS;

    localparam logic [KIND_BITS-1:0] KIND_TICK   = 2'd0;
    localparam logic [KIND_BITS-1:0] KIND_ADD    = 2'd1;
    localparam logic [KIND_BITS-1:0] KIND_DELETE = 2'd2;
    localparam logic [KIND_BITS-1:0] KIND_CHECK  = 2'd3;

    localparam logic [STATUS_BITS-1:0] STATUS_DONE = 2'd0;
    localparam logic [STATUS_BITS-1:0] STATUS_MISS = 2'd1;
    localparam logic [STATUS_BITS-1:0] STATUS_FULL = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_UPDATE,
        ST_REPORT
    } t_state;

    // Sort key: expiry in the upper bits, id below, so one unsigned compare orders both.
    typedef logic [KEY_BITS-1:0]  t_key;
    typedef logic [ADDR_BITS-1:0] t_slot;

endpackage

// File: src/stq_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module stq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: src/sorted_timer_queue.sv
// Sorted timer queue: bounded timer table with earliest-expiry tracking.
// Items are taken one at a time: o_ready is high only in the idle state, so a new item
// is taken only after the last one is reported. The linear scan of the entry RAM
// through its single read port, one slot per cycle, sets the pace; i_ready backpressure
// stalls only the report step. Reset (synchronous, active low) clears the valid marks,
// the clock, the id counter and the output valid; entry contents are left as they are.
module sorted_timer_queue (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic                                      i_valid,
    output logic                                      o_ready,
    input  logic [stq_pkg::KIND_BITS-1:0]             i_kind,
    input  logic [stq_pkg::DELAY_BITS-1:0]            i_delay_ms,
    input  logic [stq_pkg::TIME_BITS-1:0]             i_target_expire,
    input  logic [stq_pkg::ID_BITS-1:0]               i_target_id,
    output logic                                      o_valid,
    input  logic                                      i_ready,
    output logic [stq_pkg::STATUS_BITS-1:0]           o_status,
    output logic [stq_pkg::ID_BITS-1:0]               o_timer_id,
    output logic [stq_pkg::TIME_BITS-1:0]             o_expire_time,
    output logic signed [stq_pkg::SLEEP_BITS-1:0]     o_sleep_ms
);

    import stq_pkg::*;

    // Sequencer
    t_state r_state;
    t_state n_state;

    // Architectural state
    logic [CAPACITY-1:0]  r_valid;
    logic [TIME_BITS-1:0] r_time;
    logic [ID_BITS-1:0]   r_next_id;

    // Item being worked on
    logic [KIND_BITS-1:0] r_kind;
    t_key                 r_key;

    // Scan bookkeeping
    logic [ADDR_BITS:0]   r_rd_cnt;
    logic                 r_cmp_go;
    t_slot                r_cmp_slot;
    logic                 r_hit;
    t_slot                r_hit_slot;
    logic                 r_free_ok;
    t_slot                r_free_slot;
    logic                 r_has1;
    logic                 r_has2;
    t_key                 r_best;
    t_key                 r_second;
    t_slot                r_best_slot;

    // Outcome held between the update and report steps
    logic [STATUS_BITS-1:0] r_res_status;
    logic [ID_BITS-1:0]     r_res_id;
    logic [TIME_BITS-1:0]   r_res_exp;
    logic                   r_near_ok;
    logic [TIME_BITS-1:0]   r_near_exp;

    // Output register
    logic                   r_out_valid;
    logic [STATUS_BITS-1:0] r_out_status;
    logic [ID_BITS-1:0]     r_out_id;
    logic [TIME_BITS-1:0]   r_out_exp;
    logic [SLEEP_BITS-1:0]  r_out_sleep;

    // Control strobes
    logic w_accept;
    logic w_issue;
    logic w_scan_done;
    logic w_out_free;
    logic w_in_update;

    // Scan datapath
    t_key w_rd_key;
    logic w_cur_valid;
    logic w_match;
    logic w_lt_best;
    logic w_lt_second;

    // Update datapath
    logic [TIME_BITS-1:0]   w_add_exp;
    logic                   w_due;
    logic [STATUS_BITS-1:0] w_upd_status;
    logic [ID_BITS-1:0]     w_upd_id;
    logic [TIME_BITS-1:0]   w_upd_exp;
    logic                   w_upd_near_ok;
    t_key                   w_upd_near;
    logic                   w_clear_en;
    t_slot                  w_clear_slot;
    logic                   w_bump_id;
    logic                   w_wr_en;

    // Sleep datapath
    logic [TIME_BITS-1:0]  w_diff;
    logic [64:0]           w_diff_x;
    logic [SLEEP_BITS-1:0] w_sleep;

    //--------------------------------------------------------------------------
    // Entry RAM: one key per slot, read once per scan cycle, written on add.
    //--------------------------------------------------------------------------
    stq_ram #(
        .WIDTH (KEY_BITS),
        .DEPTH (CAPACITY)
    ) u_entry_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (r_free_slot),
        .i_wr_data (r_key),
        .i_rd_en   (w_issue),
        .i_rd_addr (r_rd_cnt[ADDR_BITS-1:0]),
        .o_rd_data (w_rd_key)
    );

    //--------------------------------------------------------------------------
    // Sequencer: next state
    //--------------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (w_scan_done) begin
                    n_state = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                n_state = ST_REPORT;
            end
            ST_REPORT: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    //--------------------------------------------------------------------------
    // Sequencer: control outputs
    //--------------------------------------------------------------------------
    always_comb begin
        o_ready     = (r_state == ST_IDLE);
        w_accept    = (r_state == ST_IDLE) && i_valid;
        w_issue     = (r_state == ST_SCAN) && !r_rd_cnt[ADDR_BITS];
        // The last read issued still has its compare in flight; wait it out.
        w_scan_done = (r_state == ST_SCAN) && r_rd_cnt[ADDR_BITS] && !r_cmp_go;
        w_in_update = (r_state == ST_UPDATE);
        w_out_free  = !r_out_valid || i_ready;
    end

    //--------------------------------------------------------------------------
    // Scan compare: one slot per cycle against the search key and the two
    // smallest keys seen so far. Stored keys are unique, so the runner-up is
    // the new earliest once the earliest goes away.
    //--------------------------------------------------------------------------
    always_comb begin
        w_cur_valid = r_valid[r_cmp_slot];
        w_match     = (w_rd_key == r_key);
        w_lt_best   = (w_rd_key < r_best);
        w_lt_second = (w_rd_key < r_second);
    end

    //--------------------------------------------------------------------------
    // Update step: apply the item to the table and pick the new earliest key.
    //--------------------------------------------------------------------------
    assign w_add_exp = r_time + TIME_BITS'(i_delay_ms);
    assign w_due     = (r_best[KEY_BITS-1:ID_BITS] <= r_time);

    always_comb begin
        w_upd_status  = STATUS_DONE;
        w_upd_id      = '0;
        w_upd_exp     = '0;
        w_upd_near_ok = r_has1;
        w_upd_near    = r_best;
        w_clear_en    = 1'b0;
        w_clear_slot  = r_hit_slot;
        w_bump_id     = 1'b0;
        case (r_kind)
            KIND_TICK: begin
                // Earliest key is unchanged; only the clock moves.
            end
            KIND_ADD: begin
                if (!r_free_ok) begin
                    w_upd_status = STATUS_FULL;
                end else begin
                    w_bump_id = 1'b1;
                    w_upd_id  = r_key[ID_BITS-1:0];
                    w_upd_exp = r_key[KEY_BITS-1:ID_BITS];
                    // A duplicate key adds nothing but still reports the key.
                    if (!r_hit) begin
                        w_upd_near_ok = 1'b1;
                        if (!r_has1 || (r_key < r_best)) begin
                            w_upd_near = r_key;
                        end
                    end
                end
            end
            KIND_DELETE: begin
                if (r_hit) begin
                    w_clear_en = 1'b1;
                    if (r_hit_slot == r_best_slot) begin
                        w_upd_near_ok = r_has2;
                        w_upd_near    = r_second;
                    end
                end else begin
                    w_upd_status = STATUS_MISS;
                end
            end
            KIND_CHECK: begin
                if (r_has1 && w_due) begin
                    w_clear_en    = 1'b1;
                    w_clear_slot  = r_best_slot;
                    w_upd_id      = r_best[ID_BITS-1:0];
                    w_upd_exp     = r_best[KEY_BITS-1:ID_BITS];
                    w_upd_near_ok = r_has2;
                    w_upd_near    = r_second;
                end else begin
                    w_upd_status = STATUS_MISS;
                end
            end
            default: begin
                w_upd_status = STATUS_MISS;
            end
        endcase
    end

    assign w_wr_en = w_in_update && (r_kind == KIND_ADD) && r_free_ok && !r_hit;

    //--------------------------------------------------------------------------
    // Report step: sleep time from the new earliest expiry, saturated to 32 bits.
    //--------------------------------------------------------------------------
    assign w_diff   = r_near_exp - r_time;
    assign w_diff_x = 65'(w_diff);

    always_comb begin
        if (!r_near_ok) begin
            w_sleep = '1;
        end else if (r_near_exp <= r_time) begin
            w_sleep = '0;
        end else if (w_diff_x > 65'h0_FFFF_FFFF) begin
            w_sleep = {1'b0, 32'hFFFF_FFFF};
        end else begin
            w_sleep = {1'b0, w_diff_x[31:0]};
        end
    end

    //--------------------------------------------------------------------------
    // Registers
    //--------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_valid     <= '0;
            r_time      <= '0;
            r_next_id   <= '0;
            r_rd_cnt    <= '0;
            r_cmp_go    <= 1'b0;
            r_hit       <= 1'b0;
            r_free_ok   <= 1'b0;
            r_has1      <= 1'b0;
            r_has2      <= 1'b0;
            r_near_ok   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_cmp_go   <= w_issue;
            r_cmp_slot <= r_rd_cnt[ADDR_BITS-1:0];

            // Latch the item and clear the scan trackers.
            if (w_accept) begin
                r_kind    <= i_kind;
                r_key     <= (i_kind == KIND_ADD) ? {w_add_exp, r_next_id}
                                                  : {i_target_expire, i_target_id};
                r_rd_cnt  <= '0;
                r_hit     <= 1'b0;
                r_free_ok <= 1'b0;
                r_has1    <= 1'b0;
                r_has2    <= 1'b0;
            end

            if (w_issue) begin
                r_rd_cnt <= r_rd_cnt + 1'b1;
            end

            // Fold one slot into the trackers.
            if (r_cmp_go) begin
                if (w_cur_valid) begin
                    if (w_match) begin
                        r_hit      <= 1'b1;
                        r_hit_slot <= r_cmp_slot;
                    end
                    if (!r_has1 || w_lt_best) begin
                        r_second    <= r_best;
                        r_has2      <= r_has1;
                        r_best      <= w_rd_key;
                        r_best_slot <= r_cmp_slot;
                        r_has1      <= 1'b1;
                    end else if (!r_has2 || w_lt_second) begin
                        r_second <= w_rd_key;
                        r_has2   <= 1'b1;
                    end
                end else if (!r_free_ok) begin
                    r_free_ok   <= 1'b1;
                    r_free_slot <= r_cmp_slot;
                end
            end

            // Commit the item.
            if (w_in_update) begin
                r_res_status <= w_upd_status;
                r_res_id     <= w_upd_id;
                r_res_exp    <= w_upd_exp;
                r_near_ok    <= w_upd_near_ok;
                r_near_exp   <= w_upd_near[KEY_BITS-1:ID_BITS];
                if (r_kind == KIND_TICK) begin
                    r_time <= r_time + 1'b1;
                end
                if (w_bump_id) begin
                    r_next_id <= r_next_id + 1'b1;
                end
                if (w_wr_en) begin
                    r_valid[r_free_slot] <= 1'b1;
                end
                if (w_clear_en) begin
                    r_valid[w_clear_slot] <= 1'b0;
                end
            end

            // Output register: load when the report step fires, else drop on take.
            if ((r_state == ST_REPORT) && w_out_free) begin
                r_out_valid  <= 1'b1;
                r_out_status <= r_res_status;
                r_out_id     <= r_res_id;
                r_out_exp    <= r_res_exp;
                r_out_sleep  <= w_sleep;
            end else if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid       = r_out_valid;
    assign o_status      = r_out_status;
    assign o_timer_id    = r_out_id;
    assign o_expire_time = r_out_exp;
    assign o_sleep_ms    = r_out_sleep;

endmodule

// File: src/stq_checker.sv
// Port-level checker for the sorted timer queue, bound to the top level.
`include "sorted_timer_queue_assert.svh"

module stq_checker (
    input logic                                  i_clk,
    input logic                                  i_rst_n,
    input logic                                  i_valid,
    input logic                                  o_ready,
    input logic                                  o_valid,
    input logic                                  i_ready,
    input logic [stq_pkg::STATUS_BITS-1:0]       o_status,
    input logic [stq_pkg::ID_BITS-1:0]           o_timer_id,
    input logic [stq_pkg::TIME_BITS-1:0]         o_expire_time,
    input logic signed [stq_pkg::SLEEP_BITS-1:0] o_sleep_ms
);

    import stq_pkg::*;

    // Block goes busy right after it takes an item.
    `STQ_ASSERT(a_busy_after_accept, (i_valid && o_ready) |=> !o_ready, "ready held after accept")

    // A full table reports neither id nor expiry.
    `STQ_ASSERT(a_full_no_key, (o_valid && (o_status == STATUS_FULL)) |-> ((o_timer_id == '0) && (o_expire_time == '0)), "full result carries a key")

    // Negative sleep only ever means an empty table.
    `STQ_ASSERT(a_sleep_floor, (o_valid && o_sleep_ms[SLEEP_BITS-1]) |-> (&o_sleep_ms), "sleep below -1")

    // Held result does not change while stalled.
    `STQ_ASSERT(a_out_hold, (o_valid && !i_ready) |=> (o_valid && $stable(o_status) && $stable(o_sleep_ms)), "result changed under stall")

    // No result right out of reset.
    `STQ_ASSERT_RST(a_reset_quiet, !i_rst_n |=> !o_valid, "result valid after reset")

endmodule

bind sorted_timer_queue stq_checker u_stq_checker (.*);
